// ----- rtl/u8tf_pkg.sv -----
// Shared types, constants and the letter fold table for the UTF-8 fold block.
package u8tf_pkg;

  localparam int MAX_CAPACITY = 256;
  localparam int CAP_W        = 9;
  localparam int CNT_W        = (MAX_CAPACITY > 2) ? $clog2(MAX_CAPACITY) : 1;
  localparam int Q_DEPTH      = 4;
  localparam int Q_AW         = $clog2(Q_DEPTH);
  localparam int Q_CW         = Q_AW + 1;

  localparam logic [7:0] BYTE_C3    = 8'hC3;
  localparam logic [7:0] BYTE_C4    = 8'hC4;
  localparam logic [7:0] BYTE_C5    = 8'hC5;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] CODE_LEAD2 = 8'hC0;
  localparam logic [7:0] CODE_LEAD3 = 8'hE0;
  localparam logic [7:0] CODE_LEAD4 = 8'hF0;
  localparam logic [6:0] CHAR_QMARK = 7'h3F;
  localparam logic [6:0] CHAR_NUL   = 7'h00;

  localparam logic [1:0] LEAD_NONE = 2'd0;
  localparam logic [1:0] LEAD_C3   = 2'd1;
  localparam logic [1:0] LEAD_C4   = 2'd2;
  localparam logic [1:0] LEAD_C5   = 2'd3;

  localparam logic [2:0] ADDR_CAPACITY = 3'd0;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } res_t;

  // Up to two results written into the queue in one cycle.
  typedef struct packed {
    logic [1:0] n;
    res_t       e0;
    res_t       e1;
  } push_t;

  function automatic logic [6:0] fold_pair(input logic [1:0] lead, input logic [7:0] b);
    logic [6:0] ch;
    ch = CHAR_QMARK;
    unique case (lead)
      LEAD_C3: begin
        case (b)
          8'h87:   ch = 7'h43; // C
          8'hA7:   ch = 7'h63; // c
          8'h96:   ch = 7'h4F; // O
          8'hB6:   ch = 7'h6F; // o
          8'h9C:   ch = 7'h55; // U
          8'hBC:   ch = 7'h75; // u
          default: ch = CHAR_QMARK;
        endcase
      end
      LEAD_C4: begin
        case (b)
          8'h9E:   ch = 7'h47; // G
          8'h9F:   ch = 7'h67; // g
          8'hB0:   ch = 7'h49; // I
          8'hB1:   ch = 7'h69; // i
          default: ch = CHAR_QMARK;
        endcase
      end
      LEAD_C5: begin
        case (b)
          8'h9E:   ch = 7'h53; // S
          8'h9F:   ch = 7'h73; // s
          default: ch = CHAR_QMARK;
        endcase
      end
      default: ch = CHAR_QMARK;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/u8tf_front.sv -----
// Front part: accepts bytes, tracks sequence state and issues results to the queue.
module u8tf_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [7:0]                      in_text_byte,
  input  logic                            in_end_of_text,
  input  logic [u8tf_pkg::CAP_W-1:0]      capacity,
  output u8tf_pkg::push_t                 push
);
  import u8tf_pkg::*;

  logic [1:0]       skip_r, skip_nxt;
  logic [1:0]       lead_r, lead_nxt;
  logic [CNT_W-1:0] cw_r, cw_nxt;
  logic [CNT_W-1:0] limit;
  logic             accept;
  logic             is_end;
  logic [7:0]       b;

  assign accept = in_valid && in_ready;
  assign b      = in_text_byte;
  assign is_end = in_end_of_text || (b == 8'h00);

  always_comb begin
    if (32'(capacity) > 32'(MAX_CAPACITY)) begin
      limit = CNT_W'(MAX_CAPACITY - 1);
    end else if (capacity == '0) begin
      limit = '0;
    end else begin
      limit = CNT_W'(capacity - CAP_W'(1));
    end
  end

  always_comb begin
    skip_nxt  = skip_r;
    lead_nxt  = lead_r;
    cw_nxt    = cw_r;
    push.n    = 2'd0;
    push.e0   = '{ch: CHAR_NUL, last: 1'b1};
    push.e1   = '{ch: CHAR_NUL, last: 1'b1};
    if (accept) begin
      if (is_end) begin
        // Flush a cut-short pair as '?', then close the string.
        if (lead_r != LEAD_NONE) begin
          push.n  = 2'd2;
          push.e0 = '{ch: CHAR_QMARK, last: 1'b0};
        end else begin
          push.n  = 2'd1;
        end
        skip_nxt = 2'd0;
        lead_nxt = LEAD_NONE;
        cw_nxt   = '0;
      end else if (cw_r >= limit) begin
        // Output full: drop the byte.
      end else if (skip_r != 2'd0) begin
        skip_nxt = skip_r - 2'd1;
      end else if (lead_r != LEAD_NONE) begin
        push.n   = 2'd1;
        push.e0  = '{ch: fold_pair(lead_r, b), last: 1'b0};
        lead_nxt = LEAD_NONE;
        cw_nxt   = cw_r + CNT_W'(1);
      end else if (!b[7]) begin
        push.n  = 2'd1;
        push.e0 = '{ch: b[6:0], last: 1'b0};
        cw_nxt  = cw_r + CNT_W'(1);
      end else if (b == BYTE_C3 || b == BYTE_C4 || b == BYTE_C5) begin
        lead_nxt = 2'(b - 8'hC2);
      end else begin
        push.n  = 2'd1;
        push.e0 = '{ch: CHAR_QMARK, last: 1'b0};
        cw_nxt  = cw_r + CNT_W'(1);
        if ((b & MASK_LEAD2) == CODE_LEAD2) begin
          skip_nxt = 2'd1;
        end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
          skip_nxt = 2'd2;
        end else if ((b & MASK_LEAD4) == CODE_LEAD4) begin
          skip_nxt = 2'd3;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= 2'd0;
      lead_r <= LEAD_NONE;
      cw_r   <= '0;
    end else begin
      skip_r <= skip_nxt;
      lead_r <= lead_nxt;
      cw_r   <= cw_nxt;
    end
  end

endmodule

// ----- rtl/u8tf_queue.sv -----
// Result queue between front and back: up to two writes and one read per cycle.
module u8tf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  u8tf_pkg::push_t  push,
  input  logic             pop,
  output logic             has_room,
  output logic             q_valid,
  output u8tf_pkg::res_t   q_data
);
  import u8tf_pkg::*;

  res_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] head_r, head_nxt;
  logic [Q_AW-1:0] tail_r, tail_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic            do_pop;

  // Keep room for the widest push so the front never has to stall mid-item.
  assign has_room = count_r <= Q_CW'(Q_DEPTH - 2);
  assign q_valid  = count_r != '0;
  assign q_data   = mem[head_r];
  assign do_pop   = pop && q_valid;

  always_comb begin
    head_nxt  = do_pop ? head_r + Q_AW'(1) : head_r;
    tail_nxt  = tail_r + Q_AW'(push.n);
    count_nxt = count_r + Q_CW'(push.n) - Q_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[tail_r] <= push.e0;
    end
    if (push.n == 2'd2) begin
      mem[tail_r + Q_AW'(1)] <= push.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- rtl/u8tf_back.sv -----
// Back part: moves queued results into the output register toward the consumer.
module u8tf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  u8tf_pkg::res_t  q_data,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [6:0]      out_char,
  output logic            out_last
);
  import u8tf_pkg::*;

  logic       valid_r, valid_nxt;
  logic [6:0] char_r, char_nxt;
  logic       last_r, last_nxt;

  assign pop = q_valid && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    if (pop) begin
      valid_nxt = 1'b1;
      char_nxt  = q_data.ch;
      last_nxt  = q_data.last;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

endmodule

// ----- rtl/utf8_turkish_to_ascii_fold.sv -----
// Top level of the UTF-8 to ASCII fold block with Turkish letter folding.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    in_text_byte[7:0], in_end_of_text
//   out      source     out_valid / out_ready  out_char[6:0], out_last
//   cfg      APB slave  psel/penable/pready    paddr[2:0], pwdata/prdata[31:0]
//
// One item per cycle while in_ready is high; each item is classified in the cycle it is accepted.
// An end item with a lead byte pending yields two results, which drain one per cycle while out_ready is high.
// A result passes through the result queue and then the output register to reach out_valid.
// in_ready drops while the four-entry result queue holds more than two results.
// rst_n is synchronous: sequence state clears and output_capacity returns to 256.
module utf8_turkish_to_ascii_fold (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_char,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import u8tf_pkg::*;

  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             cap_sel;
  push_t            push;
  logic             has_room;
  logic             q_valid;
  res_t             q_data;
  logic             pop;

  assign pready  = 1'b1;
  assign cap_sel = ({paddr[2], 2'b00} == ADDR_CAPACITY);

  always_comb begin
    cap_nxt = cap_r;
    if (psel && penable && pwrite && cap_sel) begin
      cap_nxt = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(256);
    end else begin
      cap_r <= cap_nxt;
    end
  end

  assign prdata   = cap_sel ? {{(32 - CAP_W){1'b0}}, cap_r} : 32'h0;
  assign in_ready = has_room;

  u8tf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (has_room),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .capacity       (cap_r),
    .push           (push)
  );

  u8tf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (pop),
    .has_room (has_room),
    .q_valid  (q_valid),
    .q_data   (q_data)
  );

  u8tf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule
